>>> src/xor_parity_frame_recovery_defines.svh
// Assertion macros for the XOR parity frame recovery block.
// Included by the top level; no other dependencies.
`ifndef XOR_PARITY_FRAME_RECOVERY_DEFINES_SVH
`define XOR_PARITY_FRAME_RECOVERY_DEFINES_SVH
`ifndef SYNTHESIS
`define XPFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xpfr: implication check failed");
`define XPFR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("xpfr: forbidden condition seen");
`else
`define XPFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define XPFR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/xpfr_pkg.sv
// Shared types, codes and constants of the XOR parity frame recovery block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xpfr_pkg;

    localparam int ROW_W     = 320;
    localparam int CNT_W     = 6;
    localparam logic [CNT_W-1:0] MAX_RES = 6'd40;
    localparam logic [CNT_W-1:0] RB_ROOM = 6'd36;

    typedef enum logic [1:0] {
        CMD_PAYLOAD = 2'd0,
        CMD_PARITY  = 2'd1,
        CMD_HEADER  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seq;
        logic [1:0]  chunk;
        logic [63:0] word0;
        logic [63:0] word1;
        logic [63:0] word2;
        logic [63:0] word3;
        logic [63:0] word4;
        logic        end_of_packet;
    } t_in;

    typedef struct packed {
        logic [31:0] out_seq;
        logic [1:0]  out_chunk;
        logic [63:0] out_word0;
        logic [63:0] out_word1;
        logic [63:0] out_word2;
        logic [63:0] out_word3;
        logic [63:0] out_word4;
        logic        recovered;
        logic        last_of_run;
    } t_out;

    // classified item as it leaves the front end
    typedef struct packed {
        logic             is_pay;
        logic             is_par;
        logic [31:0]      seq;
        logic [1:0]       chunk;
        logic [ROW_W-1:0] row;
        logic             eop;
    } t_job;

    typedef struct packed {
        logic [31:0] tag;
        logic        seen;
        logic        held;
    } t_meta;

    typedef struct packed {
        logic             clearing;
        logic [CNT_W-1:0] res_cnt;
    } t_bk_stat;

    function automatic t_out mk_out(input logic [31:0] seq, input logic [1:0] chunk,
                                    input logic [ROW_W-1:0] row, input logic rec);
        t_out o;
        o.out_seq     = seq;
        o.out_chunk   = chunk;
        o.out_word0   = row[319:256];
        o.out_word1   = row[255:192];
        o.out_word2   = row[191:128];
        o.out_word3   = row[127:64];
        o.out_word4   = row[63:0];
        o.recovered   = rec;
        o.last_of_run = 1'b0;
        return o;
    endfunction

endpackage
`default_nettype wire

>>> src/xpfr_fifo.sv
// Two-entry transaction queue between front and back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module xpfr_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

>>> src/xpfr_front.sv
// Front end: takes input transactions, classifies them and finds the ring slot
// (seq mod WINDOW, four bits per cycle). Uses xpfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xpfr_front #(
    parameter int WINDOW = 64,
    parameter int SLOT_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire xpfr_pkg::t_in     i_in_data,
    output logic                   o_in_stall,
    input  wire logic              i_clearing,
    input  wire logic              i_full,
    output logic                   o_push,
    output xpfr_pkg::t_job         o_job,
    output logic [SLOT_W-1:0]      o_slot
);
    localparam logic [SLOT_W:0] WIN_C = (SLOT_W+1)'(WINDOW);

    xpfr_pkg::t_job    r_job, n_job;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [2:0]        r_step;
    logic              r_busy, r_done;
    logic              accept;
    logic [31:0]       sh;
    logic [SLOT_W:0]   t;

    assign o_in_stall = r_busy | (r_done & i_full) | i_clearing;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_done & ~i_full;
    assign o_job      = r_job;
    assign o_slot     = r_rem;

    // restoring remainder, one nibble of seq per cycle
    always_comb begin
        sh = r_job.seq << {r_step, 2'b00};
        t  = '0;
        n_rem = r_rem;
        for (int b = 0; b < 4; b++) begin
            t = {n_rem, sh[31-b]};
            if (t >= WIN_C) t = t - WIN_C;
            n_rem = t[SLOT_W-1:0];
        end
    end

    always_comb begin
        n_job        = r_job;
        n_job.is_pay = 1'b0;
        n_job.is_par = 1'b0;
        unique case (xpfr_pkg::t_cmd'(i_in_data.command))
            xpfr_pkg::CMD_PAYLOAD: n_job.is_pay = 1'b1;
            xpfr_pkg::CMD_PARITY:  n_job.is_par = 1'b1;
            xpfr_pkg::CMD_HEADER:  n_job.is_pay = 1'b0;
            default:               n_job.is_par = 1'b0;
        endcase
        n_job.seq   = i_in_data.seq;
        n_job.chunk = i_in_data.chunk;
        n_job.row   = {i_in_data.word0, i_in_data.word1, i_in_data.word2,
                       i_in_data.word3, i_in_data.word4};
        n_job.eop   = i_in_data.end_of_packet;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
            r_rem  <= '0;
        end else begin
            if (o_push) r_done <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> src/xpfr_back.sv
// Back end: slot bookkeeping, frame and parity stores, recovery sweep and the
// output register. Uses xpfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xpfr_back #(
    parameter int WINDOW       = 64,
    parameter int SWEEP_BEHIND = 5,
    parameter int SWEEP_AHEAD  = 2,
    parameter int SLOT_W       = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire xpfr_pkg::t_job    i_job,
    input  wire logic [SLOT_W-1:0] i_slot,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output xpfr_pkg::t_out         o_out_data,
    input  wire logic              i_out_stall,
    output xpfr_pkg::t_bk_stat     o_stat
);
    localparam int ROWS = WINDOW * 4;
    localparam int RW   = SLOT_W + 2;
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW - 1);
    localparam logic [SLOT_W:0]   WIN_C    = (SLOT_W+1)'(WINDOW);
    localparam logic [32:0]       SB33     = 33'(SWEEP_BEHIND);
    localparam logic [32:0]       SA33     = 33'(SWEEP_AHEAD);
    localparam int PW = xpfr_pkg::ROW_W;
    localparam int CW = xpfr_pkg::CNT_W;

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_LOOK = 11'b00000000100,
        S_CMD  = 11'b00000001000,
        S_SWP  = 11'b00000010000,
        S_SWH  = 11'b00000100000,
        S_SW1  = 11'b00001000000,
        S_SW2  = 11'b00010000000,
        S_RBA  = 11'b00100000000,
        S_RBD  = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] a,
                                                   input logic [3:0] d);
        logic [SLOT_W:0] t;
        t = {1'b0, a} + WIN_C - (SLOT_W+1)'(d);
        if (t >= WIN_C) t = t - WIN_C;
        return t[SLOT_W-1:0];
    endfunction

    // storage
    xpfr_pkg::t_meta r_meta_mem  [WINDOW];
    logic [PW-1:0]   r_frame_mem [ROWS];
    logic [PW-1:0]   r_par_mem   [ROWS];
    xpfr_pkg::t_meta r_meta_rd;
    logic [PW-1:0]   r_fr_rd, r_par_rd;

    // control
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr_idx, n_clr_idx;
    xpfr_pkg::t_job    r_job, n_job;
    logic [SLOT_W-1:0] r_slot_q, n_slot_q;
    logic [32:0]       r_s, n_s, r_lo, n_lo, r_hi, n_hi;
    logic [SLOT_W-1:0] r_ps, n_ps, r_slot_lo, n_slot_lo;
    logic              r_again, n_again;
    logic [CW-1:0]     r_cnt, n_cnt;
    xpfr_pkg::t_meta   r_m1, n_m1;
    logic [31:0]       r_tgt, n_tgt;
    logic [SLOT_W-1:0] r_tslot, n_tslot, r_sslot, n_sslot;
    logic              r_theld, n_theld;
    logic [1:0]        r_c, n_c;
    logic              r_pend_valid, n_pend_valid;
    xpfr_pkg::t_out    r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    xpfr_pkg::t_out    r_out, n_out;

    // memory port controls
    logic [SLOT_W-1:0] meta_raddr, meta_waddr;
    logic              meta_we;
    xpfr_pkg::t_meta   meta_wdata;
    logic              fr_we, par_we;
    logic [RW-1:0]     fr_waddr, par_waddr, fr_raddr, par_raddr;
    logic [PW-1:0]     fr_wdata, par_wdata, rb_row;

    logic              out_free, do_adv, set_again, match, k1, k2;
    logic [31:0]       s1, s2;
    logic [SLOT_W-1:0] ps1, ps2;
    logic [3:0]        span_back;

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_stat.clearing = (r_state == S_CLR);
    assign o_stat.res_cnt  = r_cnt;

    assign s1     = r_s[31:0] - 32'd1;
    assign s2     = r_s[31:0] - 32'd2;
    assign ps1    = slot_sub(r_ps, 4'd1);
    assign ps2    = slot_sub(r_ps, 4'd2);
    assign rb_row = r_fr_rd ^ r_par_rd;

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_job        = r_job;
        n_slot_q     = r_slot_q;
        n_s          = r_s;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_ps         = r_ps;
        n_slot_lo    = r_slot_lo;
        n_again      = r_again;
        n_cnt        = r_cnt;
        n_m1         = r_m1;
        n_tgt        = r_tgt;
        n_tslot      = r_tslot;
        n_sslot      = r_sslot;
        n_theld      = r_theld;
        n_c          = r_c;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        out_free     = ~r_out_valid | ~i_out_stall;
        n_out_valid  = r_out_valid & i_out_stall;
        n_out        = r_out;
        o_pop        = 1'b0;
        meta_raddr   = r_ps;
        meta_we      = 1'b0;
        meta_waddr   = r_slot_q;
        meta_wdata   = '0;
        fr_we        = 1'b0;
        fr_waddr     = {r_slot_q, r_job.chunk};
        fr_wdata     = r_job.row;
        par_we       = 1'b0;
        par_waddr    = {r_slot_q, r_job.chunk};
        par_wdata    = r_job.row;
        fr_raddr     = {r_sslot, r_c};
        par_raddr    = {r_ps, r_c};
        do_adv       = 1'b0;
        set_again    = 1'b0;
        match        = (r_meta_rd.tag == r_job.seq);
        k1           = (r_m1.tag == s1) & r_m1.seen;
        k2           = (r_meta_rd.tag == s2) & r_meta_rd.seen;
        span_back    = (r_job.seq >= 32'(SWEEP_BEHIND)) ? 4'(SWEEP_BEHIND)
                                                        : r_job.seq[3:0];

        unique case (r_state)
            S_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr_idx;
                meta_wdata = '0;
                n_clr_idx  = r_clr_idx + SLOT_W'(1);
                if (r_clr_idx == SLOT_MAX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_job    = i_job;
                    n_slot_q = i_slot;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                meta_raddr = r_slot_q;
                n_state    = S_CMD;
            end
            S_CMD: begin
                n_cnt = '0;
                if (r_job.is_pay && !(match && r_meta_rd.seen)) begin
                    fr_we           = 1'b1;
                    meta_we         = 1'b1;
                    meta_wdata.tag  = r_job.seq;
                    meta_wdata.seen = (r_job.chunk == 2'd3);
                    meta_wdata.held = match & r_meta_rd.held;
                    n_pend_valid    = 1'b1;
                    n_pend          = xpfr_pkg::mk_out(r_job.seq, r_job.chunk,
                                                       r_job.row, 1'b0);
                    n_cnt           = CW'(1);
                end
                if (r_job.is_par) begin
                    par_we          = 1'b1;
                    meta_we         = 1'b1;
                    meta_wdata.tag  = r_job.seq;
                    meta_wdata.seen = match & r_meta_rd.seen;
                    meta_wdata.held = (match & r_meta_rd.held) | (r_job.chunk == 2'd3);
                end
                n_lo      = ({1'b0, r_job.seq} >= SB33) ? {1'b0, r_job.seq} - SB33 : '0;
                n_hi      = {1'b0, r_job.seq} + SA33;
                n_slot_lo = slot_sub(r_slot_q, span_back);
                n_s       = n_lo;
                n_ps      = n_slot_lo;
                n_again   = 1'b0;
                n_state   = r_job.eop ? S_SWP : S_FIN;
            end
            S_SWP: begin
                if (r_s < 33'd2 || r_s[32]) begin
                    do_adv = 1'b1;
                end else begin
                    meta_raddr = r_ps;
                    n_state    = S_SWH;
                end
            end
            S_SWH: begin
                meta_raddr = ps1;
                if ((r_meta_rd.tag == r_s[31:0]) && r_meta_rd.held) n_state = S_SW1;
                else do_adv = 1'b1;
            end
            S_SW1: begin
                n_m1       = r_meta_rd;
                meta_raddr = ps2;
                n_state    = S_SW2;
            end
            S_SW2: begin
                n_c = 2'd0;
                if (r_cnt <= xpfr_pkg::RB_ROOM && k1 && !k2) begin
                    n_tgt   = s2;
                    n_tslot = ps2;
                    n_sslot = ps1;
                    n_theld = (r_meta_rd.tag == s2) & r_meta_rd.held;
                    n_state = S_RBA;
                end else if (r_cnt <= xpfr_pkg::RB_ROOM && !k1 && k2) begin
                    n_tgt   = s1;
                    n_tslot = ps1;
                    n_sslot = ps2;
                    n_theld = (r_m1.tag == s1) & r_m1.held;
                    n_state = S_RBA;
                end else begin
                    do_adv = 1'b1;
                end
            end
            S_RBA: begin
                n_state = S_RBD;
            end
            S_RBD: begin
                if (!r_pend_valid || out_free) begin
                    fr_we    = 1'b1;
                    fr_waddr = {r_tslot, r_c};
                    fr_wdata = rb_row;
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                    end
                    n_pend_valid = 1'b1;
                    n_pend       = xpfr_pkg::mk_out(r_tgt, r_c, rb_row, 1'b1);
                    if (r_c == 2'd3) begin
                        meta_we         = 1'b1;
                        meta_waddr      = r_tslot;
                        meta_wdata.tag  = r_tgt;
                        meta_wdata.seen = 1'b1;
                        meta_wdata.held = r_theld;
                        n_cnt           = r_cnt + CW'(4);
                        set_again       = 1'b1;
                        do_adv          = 1'b1;
                    end else begin
                        n_c     = r_c + 2'd1;
                        n_state = S_RBA;
                    end
                end
            end
            S_FIN: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = r_pend;
                    n_out.last_of_run = 1'b1;
                    n_pend_valid      = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase

        // step to the next parity slot; at the end restart the pass if anything was rebuilt, else finish
        if (do_adv) begin
            if (r_s == r_hi) begin
                if (r_again || set_again) begin
                    n_s     = r_lo;
                    n_ps    = r_slot_lo;
                    n_again = 1'b0;
                    n_state = S_SWP;
                end else begin
                    n_state = S_FIN;
                end
            end else begin
                n_s     = r_s + 33'd1;
                n_ps    = (r_ps == SLOT_MAX) ? '0 : r_ps + SLOT_W'(1);
                n_again = r_again | set_again;
                n_state = S_SWP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) r_meta_mem[meta_waddr] <= meta_wdata;
        r_meta_rd <= r_meta_mem[meta_raddr];
        if (fr_we) r_frame_mem[fr_waddr] <= fr_wdata;
        r_fr_rd <= r_frame_mem[fr_raddr];
        if (par_we) r_par_mem[par_waddr] <= par_wdata;
        r_par_rd <= r_par_mem[par_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_slot_q  <= n_slot_q;
        r_s       <= n_s;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_ps      <= n_ps;
        r_slot_lo <= n_slot_lo;
        r_m1      <= n_m1;
        r_tgt     <= n_tgt;
        r_tslot   <= n_tslot;
        r_sslot   <= n_sslot;
        r_theld   <= n_theld;
        r_c       <= n_c;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_idx    <= '0;
            r_again      <= 1'b0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_again      <= n_again;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

>>> src/xor_parity_frame_recovery.sv
// XOR parity frame recovery receiver (parity span two). Frames of 160 bytes
// arrive as four 40-byte chunk transactions; a payload chunk is stored and
// forwarded unless its frame is complete, then dropped; parity chunks are
// stored. On end_of_packet the parity slots seq-SWEEP_BEHIND..seq+SWEEP_AHEAD
// are swept, and where one of the two covered frames is missing it is rebuilt
// by XOR and emitted as four chunks with recovered set; passes repeat until
// nothing new comes out, at most 40 results per transaction. last_of_run
// marks the final result of a transaction. After reset a clearing pass over
// all WINDOW slots empties the slot tags; input stalls until it ends. The
// front end finds the seq mod WINDOW remainder four bits a cycle, overlapping
// with the back end. The back end looks up the slot, applies the command and,
// when sweeping, reads the tags of each parity slot and its two frames in
// turn and rebuilds a lost frame chunk by chunk, limited by the single read
// port of the slot table and of each store. Results leave through one output
// register; the one before it holds back so last_of_run can be known. Uses
// xpfr_pkg, xpfr_front, xpfr_fifo, xpfr_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "xor_parity_frame_recovery_defines.svh"
module xor_parity_frame_recovery #(
    parameter int WINDOW       = 64,
    parameter int SWEEP_BEHIND = 5,
    parameter int SWEEP_AHEAD  = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire xpfr_pkg::t_in  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output xpfr_pkg::t_out      o_out_data,
    input  wire logic           i_out_stall
);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int QW     = SLOT_W + $bits(xpfr_pkg::t_job);

    logic                push, pop, full, empty;
    xpfr_pkg::t_job      f_job, b_job;
    logic [SLOT_W-1:0]   f_slot, b_slot;
    logic [QW-1:0]       q_out;
    xpfr_pkg::t_bk_stat  stat;

    xpfr_front #(.WINDOW(WINDOW), .SLOT_W(SLOT_W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_clearing (stat.clearing),
        .i_full     (full),
        .o_push     (push),
        .o_job      (f_job),
        .o_slot     (f_slot)
    );

    // queue decouples the classifier from the sweep engine
    xpfr_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_slot, f_job}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign b_slot = q_out[QW-1 -: SLOT_W];
    assign b_job  = xpfr_pkg::t_job'(q_out[QW-SLOT_W-1:0]);

    xpfr_back #(
        .WINDOW       (WINDOW),
        .SWEEP_BEHIND (SWEEP_BEHIND),
        .SWEEP_AHEAD  (SWEEP_AHEAD),
        .SLOT_W       (SLOT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (b_job),
        .i_slot      (b_slot),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat)
    );

    // no transaction gets in while the slot table is being cleared
    `XPFR_ASSERT_NEVER(a_no_accept_clr, i_clk, i_rst_n, stat.clearing && i_in_valid && !o_in_stall)
    // nothing can come out while the slot table is cleared, before the first transaction was taken
    `XPFR_ASSERT_IMP(a_no_out_clr, i_clk, i_rst_n, stat.clearing, !o_out_valid)
    // result budget per transaction
    `XPFR_ASSERT_NEVER(a_res_budget, i_clk, i_rst_n, stat.res_cnt > xpfr_pkg::MAX_RES)
endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for xor_parity_frame_recovery: a scoreboard class
// predicts forwarded and rebuilt frame chunks and checks every result in order.
// Depends on xpfr_pkg and the xor_parity_frame_recovery RTL.
`timescale 1ns / 1ps

class frame_recovery_scoreboard;
    localparam int SLOTS       = 64;
    localparam int SLOT_WORDS  = 20;
    localparam int SPAN_BACK   = 5;
    localparam int SPAN_AHEAD  = 2;
    localparam int RESULT_CAP  = 40;

    // Mirror of the block's storage
    logic [63:0] frame_mem  [SLOTS*SLOT_WORDS];
    logic [63:0] parity_mem [SLOTS*SLOT_WORDS];
    logic [31:0] owner      [SLOTS];
    bit          seen       [SLOTS];
    bit          held       [SLOTS];
    // Chunks ever written per slot; keeps the stimulus off unwritten entries
    bit   [3:0]  frame_written  [SLOTS];
    bit   [3:0]  parity_written [SLOTS];

    xpfr_pkg::t_out expected_chunks[$];
    xpfr_pkg::t_out run_chunks[$];
    int mismatches;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            owner[i] = '0;
            seen[i] = 0;
            held[i] = 0;
            frame_written[i] = '0;
            parity_written[i] = '0;
        end
        mismatches = 0;
    endfunction

    function int pending();
        return expected_chunks.size();
    endfunction

    function bit frame_known(longint q);
        int i;
        if (q > 64'hFFFF_FFFF || q < 0) return 0;
        i = int'(q % SLOTS);
        return owner[i] == q[31:0] && seen[i];
    endfunction

    function bit parity_present(longint q);
        int i;
        if (q > 64'hFFFF_FFFF || q < 0) return 0;
        i = int'(q % SLOTS);
        return owner[i] == q[31:0] && held[i];
    endfunction

    function int take_slot(logic [31:0] q);
        int i;
        i = int'(q % SLOTS);
        if (owner[i] != q) begin
            owner[i] = q;
            seen[i] = 0;
            held[i] = 0;
        end
        return i;
    endfunction

    function void push_chunk(logic [31:0] q, logic [1:0] c, logic [319:0] row, logic rec);
        xpfr_pkg::t_out o;
        o.out_seq     = q;
        o.out_chunk   = c;
        o.out_word0   = row[319:256];
        o.out_word1   = row[255:192];
        o.out_word2   = row[191:128];
        o.out_word3   = row[127:64];
        o.out_word4   = row[63:0];
        o.recovered   = rec;
        o.last_of_run = 1'b0;
        run_chunks.push_back(o);
    endfunction

    // XOR parity with the surviving frame gives the lost one
    function bit rebuild_frame(logic [31:0] target, logic [31:0] source, logic [31:0] par);
        int ti, si, pi, off;
        logic [319:0] row;
        if (run_chunks.size() + 4 > RESULT_CAP) return 0;
        si = int'(source % SLOTS);
        pi = int'(par % SLOTS);
        ti = take_slot(target);
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 5; k++) begin
                off = c * 5 + k;
                row[319 - 64*k -: 64] = parity_mem[pi*SLOT_WORDS + off]
                                        ^ frame_mem[si*SLOT_WORDS + off];
                frame_mem[ti*SLOT_WORDS + off] = row[319 - 64*k -: 64];
            end
            push_chunk(target, c[1:0], row, 1'b1);
        end
        seen[ti] = 1;
        frame_written[ti] = 4'hF;
        return 1;
    endfunction

    function void sweep_window(logic [31:0] q);
        longint lo, hi, s;
        bit again, k1, k2;
        lo = (q >= SPAN_BACK) ? longint'(q) - SPAN_BACK : 0;
        hi = longint'(q) + SPAN_AHEAD;
        again = 1;
        while (again) begin
            again = 0;
            for (s = lo; s <= hi; s++) begin
                if (s < 2 || !parity_present(s)) continue;
                k1 = frame_known(s - 1);
                k2 = frame_known(s - 2);
                if (k1 && !k2) begin
                    if (rebuild_frame(s[31:0] - 2, s[31:0] - 1, s[31:0])) again = 1;
                end else if (!k1 && k2) begin
                    if (rebuild_frame(s[31:0] - 1, s[31:0] - 2, s[31:0])) again = 1;
                end
            end
        end
    endfunction

    function void note_transaction(xpfr_pkg::t_in t);
        int i;
        logic [319:0] row;
        row = {t.word0, t.word1, t.word2, t.word3, t.word4};
        run_chunks.delete();
        if (t.command == xpfr_pkg::CMD_PAYLOAD) begin
            if (!frame_known(longint'(t.seq))) begin
                i = take_slot(t.seq);
                for (int k = 0; k < 5; k++)
                    frame_mem[i*SLOT_WORDS + t.chunk*5 + k] = row[319 - 64*k -: 64];
                frame_written[i][t.chunk] = 1;
                push_chunk(t.seq, t.chunk, row, 1'b0);
                if (t.chunk == 2'd3) seen[i] = 1;
            end
        end else if (t.command == xpfr_pkg::CMD_PARITY) begin
            i = take_slot(t.seq);
            for (int k = 0; k < 5; k++)
                parity_mem[i*SLOT_WORDS + t.chunk*5 + k] = row[319 - 64*k -: 64];
            parity_written[i][t.chunk] = 1;
            if (t.chunk == 2'd3) held[i] = 1;
        end
        if (t.end_of_packet) sweep_window(t.seq);
        if (run_chunks.size() > 0) run_chunks[run_chunks.size()-1].last_of_run = 1'b1;
        foreach (run_chunks[n]) expected_chunks.push_back(run_chunks[n]);
    endfunction

    function void check_result(xpfr_pkg::t_out got);
        xpfr_pkg::t_out want;
        if (expected_chunks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result seq=%h chunk=%0d", got.out_seq, got.out_chunk);
            return;
        end
        want = expected_chunks.pop_front();
        if (got.out_seq !== want.out_seq || got.out_chunk !== want.out_chunk
                || got.out_word0 !== want.out_word0 || got.out_word1 !== want.out_word1
                || got.out_word2 !== want.out_word2 || got.out_word3 !== want.out_word3
                || got.out_word4 !== want.out_word4 || got.recovered !== want.recovered
                || got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: result mismatch");
                $display("  expected %h", want);
                $display("  actual   %h", got);
            end
        end
    endfunction
endclass

module tb_top;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT   = 20000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 200;
    localparam int         RANDOM_ITEMS = 70;
    // Word fill patterns for directed transactions
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    xpfr_pkg::t_in  i_in_data;
    logic           o_in_stall;
    logic           o_out_valid;
    xpfr_pkg::t_out o_out_data;
    logic           i_out_stall;

    frame_recovery_scoreboard sb;
    int  items_sent;
    int  idle_cycles;
    bit  no_idle;       // stretch with both sides at full rate
    bit  hold_request;  // asks the receiver for one long stall

    xor_parity_frame_recovery dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result check and progress watchdog; both sample pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic xpfr_pkg::t_in make_item(logic [1:0] cmd, logic [31:0] s,
                                                logic [1:0] c, logic eop, int fill);
        xpfr_pkg::t_in t;
        logic [63:0] w [5];
        for (int k = 0; k < 5; k++) begin
            case (fill)
                FILL_ZERO: w[k] = '0;
                FILL_ONES: w[k] = '1;
                default:   w[k] = {$urandom, $urandom};
            endcase
        end
        t.command = cmd;
        t.seq = s;
        t.chunk = c;
        t.word0 = w[0];
        t.word1 = w[1];
        t.word2 = w[2];
        t.word3 = w[3];
        t.word4 = w[4];
        t.end_of_packet = eop;
        return t;
    endfunction

    // Chunk 3 completes a block, so it only goes out once the other chunks
    // of that slot's store were written
    function automatic logic [1:0] safe_chunk(logic [1:0] cmd, logic [31:0] s, logic [1:0] c);
        bit [3:0] done;
        int       slot;
        slot = int'(s % 64);
        done = (cmd == xpfr_pkg::CMD_PARITY) ? sb.parity_written[slot]
                                             : sb.frame_written[slot];
        if (c == 2'd3 && (done | 4'b1000) != 4'hF) return 2'($urandom_range(0, 2));
        return c;
    endfunction

    // One input transaction; a random gap first unless at full rate
    task automatic send_transaction(input xpfr_pkg::t_in item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_transaction(item);
        items_sent++;
    endtask

    task automatic send_frame(logic [1:0] cmd, logic [31:0] s, logic eop_last, int fill);
        for (int c = 0; c < 4; c++)
            send_transaction(make_item(cmd, s, c[1:0], eop_last && c == 3, fill));
    endtask

    // Stray transaction: any command including the unused code
    task automatic send_noise(logic [31:0] base);
        logic [1:0]  cmd;
        logic [31:0] s;
        logic [1:0]  c;
        cmd = 2'($urandom_range(0, 3));
        s = $urandom_range(0, 1) ? base + $urandom_range(0, 10) : $urandom;
        c = safe_chunk(cmd, s, 2'($urandom_range(0, 3)));
        send_transaction(make_item(cmd, s, c, 1'($urandom_range(0, 1)), FILL_RANDOM));
    endtask

    // A run of consecutive frames, some lost, most followed by parity
    task automatic send_frame_run();
        logic [31:0] base, s;
        int          len;
        bit          pay, par;
        base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF8 + $urandom_range(0, 4) : $urandom;
        len = $urandom_range(3, 7);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < len; j++) begin
            s = base + j;
            pay = ($urandom_range(0, 9) < 8);
            par = ($urandom_range(0, 9) < 6);
            if (pay) send_frame(xpfr_pkg::CMD_PAYLOAD, s, !par, FILL_RANDOM);
            if (par) send_frame(xpfr_pkg::CMD_PARITY, s, 1'b1, FILL_RANDOM);
            if ($urandom_range(0, 9) == 0)
                send_transaction(make_item(xpfr_pkg::CMD_PAYLOAD, s,
                                           safe_chunk(xpfr_pkg::CMD_PAYLOAD, s,
                                                      2'($urandom_range(0, 3))),
                                           1'($urandom_range(0, 1)), FILL_RANDOM));
            if ($urandom_range(0, 9) == 0) send_noise(base);
        end
    endtask

    // Receiver: random stall before each result, plus one long hold-off
    initial begin
        int n;
        bit hold_done;
        hold_done = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1;
            end
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int directed_count;
        sb = new();
        items_sent = 0;
        idle_cycles = 0;
        no_idle = 0;
        hold_request = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: frame 0 of zeros, parity at 2 rebuilds frame 1
        send_frame(xpfr_pkg::CMD_PAYLOAD, 32'd0, 1'b1, FILL_ZERO);
        send_frame(xpfr_pkg::CMD_PARITY, 32'd2, 1'b1, FILL_ONES);
        // Repeat of a known frame is dropped
        send_transaction(make_item(xpfr_pkg::CMD_PAYLOAD, 32'd0, 2'd1, 1'b1, FILL_ONES));
        // Header only and the unused command still sweep
        send_transaction(make_item(xpfr_pkg::CMD_HEADER, 32'd3, 2'd0, 1'b1, FILL_RANDOM));
        send_transaction(make_item(CMD_UNUSED, 32'd4, 2'd2, 1'b1, FILL_RANDOM));
        // Top of the sequence space: sweep must stop at the wrap
        send_frame(xpfr_pkg::CMD_PAYLOAD, 32'hFFFF_FFFE, 1'b0, FILL_ONES);
        send_frame(xpfr_pkg::CMD_PARITY, 32'hFFFF_FFFF, 1'b1, FILL_RANDOM);
        send_transaction(make_item(xpfr_pkg::CMD_PAYLOAD, 32'hFFFF_FFFF, 2'd0, 1'b1,
                                   FILL_ONES));
        directed_count = items_sent;

        // Sender holds back until the block has drained
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);

        // Receiver stalls long while traffic piles up; each run picks its own rate
        hold_request = 1;
        no_idle = 1;
        send_frame_run();
        while (items_sent < directed_count + RANDOM_ITEMS) send_frame_run();

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/xpfr_pkg.sv
src/xpfr_fifo.sv
src/xpfr_front.sv
src/xpfr_back.sv
src/xor_parity_frame_recovery.sv
test/tb_top.sv
